// ===== rtl/core/qlod_pkg.sv =====
// ----------------------------------------------------------------------------
// qlod_pkg
// shared types, register map and constants of the quadtree lod node selector
// ----------------------------------------------------------------------------
package qlod_pkg;

    localparam int MAX_LEVELS_DEF = 16;
    localparam int RANGE_REGS_DEF = 5;

    localparam int PADDR_W  = 5;
    localparam int COORD_W  = 17;
    localparam int LEVEL_W  = 4;
    localparam int COUNT_W  = 3;
    localparam int RANGE_W  = 32;
    localparam int EYE_W    = 32;
    localparam int GAP_W    = 33;
    localparam int PROD_W   = 66;
    localparam int CHILD_W  = 2;

    localparam logic [COORD_W-1:0] ROOT_SIZE_RST   = 17'd4096;
    localparam logic [LEVEL_W-1:0] ROOT_LEVEL_RST  = 4'd7;
    localparam logic [COUNT_W-1:0] RANGE_COUNT_RST = 3'd6;
    localparam logic [4:0][RANGE_W-1:0] RANGE_RST  = {
        32'd800000, 32'd320000, 32'd128000, 32'd51200, 32'd20480
    };

    localparam logic [CHILD_W-1:0] CHILD_FIRST = 2'd0;
    localparam logic [CHILD_W-1:0] CHILD_LAST  = 2'd3;

    typedef enum logic [2:0] {
        REG_ROOT_SIZE   = 3'd0,
        REG_ROOT_LEVEL  = 3'd1,
        REG_RANGE_COUNT = 3'd2,
        REG_RANGE1      = 3'd3,
        REG_RANGE2      = 3'd4,
        REG_RANGE3      = 3'd5,
        REG_RANGE4      = 3'd6,
        REG_RANGE5      = 3'd7
    } reg_idx_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_FETCH = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_NODE    = 2'd0,
        STATUS_DONE    = 2'd1,
        STATUS_STARTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SQ_NONE = 2'd0,
        SQ_LOAD = 2'd1,
        SQ_ADD  = 2'd2,
        SQ_CMP  = 2'd3
    } sq_kind_t;

    typedef struct packed {
        sq_kind_t         kind;
        logic [GAP_W-1:0] op;
    } sq_cmd_t;

    typedef struct packed {
        logic done;
        logic in_range;
    } sq_res_t;

    typedef struct packed {
        logic [COORD_W-1:0] root_size;
        logic [LEVEL_W-1:0] root_level;
        logic [COUNT_W-1:0] range_count;
    } qlod_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_DX,
        ST_DZ,
        ST_DY,
        ST_DR,
        ST_DWAIT,
        ST_LD_RD,
        ST_LD_ACC,
        ST_ADV_CHK,
        ST_ADV_DATA
    } walk_state_t;

endpackage

// ===== rtl/core/qlod_ram.sv =====
// ----------------------------------------------------------------------------
// qlod_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module qlod_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/qlod_sq.sv =====
// ----------------------------------------------------------------------------
// qlod_sq
// shared square and accumulate unit for the squared box distance test
// ----------------------------------------------------------------------------
module qlod_sq (
    input  logic              clk,
    input  logic              rst_n,
    input  qlod_pkg::sq_cmd_t cmd,
    output qlod_pkg::sq_res_t res
);
    import qlod_pkg::*;

    sq_kind_t          a_kind_reg;
    sq_kind_t          p_kind_reg;
    logic [GAP_W-1:0]  a_op_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;
    logic              in_range_reg;
    logic [PROD_W-1:0] sq_prod;

    assign sq_prod = PROD_W'(a_op_reg) * PROD_W'(a_op_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_kind_reg <= SQ_NONE;
            p_kind_reg <= SQ_NONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            a_kind_reg <= cmd.kind;
            p_kind_reg <= a_kind_reg;
            done_reg   <= (p_kind_reg == SQ_CMP);
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg <= cmd.op;
        prod_reg <= sq_prod;
        unique case (p_kind_reg)
            SQ_LOAD: acc_reg <= prod_reg;
            SQ_ADD:  acc_reg <= acc_reg + prod_reg;
            SQ_CMP:  in_range_reg <= (acc_reg <= prod_reg);
            default: ;
        endcase
    end

    assign res.done     = done_reg;
    assign res.in_range = in_range_reg;

endmodule

// ===== rtl/core/qlod_cfg.sv =====
// ----------------------------------------------------------------------------
// qlod_cfg
// apb register file: root node, range count and per level switch distances
// ----------------------------------------------------------------------------
module qlod_cfg #(
    parameter int RANGE_REGS = qlod_pkg::RANGE_REGS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [qlod_pkg::PADDR_W-1:0]             paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    output qlod_pkg::qlod_cfg_t                      cfg,
    output logic [RANGE_REGS-1:0][qlod_pkg::RANGE_W-1:0] ranges
);
    import qlod_pkg::*;

    logic [COORD_W-1:0]                 root_size_reg;
    logic [LEVEL_W-1:0]                 root_level_reg;
    logic [COUNT_W-1:0]                 range_count_reg;
    logic [RANGE_REGS-1:0][RANGE_W-1:0] range_reg;
    logic                               wr_en;
    reg_idx_t                           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_size_reg   <= ROOT_SIZE_RST;
            root_level_reg  <= ROOT_LEVEL_RST;
            range_count_reg <= RANGE_COUNT_RST;
            for (int k = 0; k < RANGE_REGS; k++)
            begin
                range_reg[k] <= RANGE_RST[k];
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROOT_SIZE:   root_size_reg   <= pwdata[COORD_W-1:0];
                REG_ROOT_LEVEL:  root_level_reg  <= pwdata[LEVEL_W-1:0];
                REG_RANGE_COUNT: range_count_reg <= pwdata[COUNT_W-1:0];
                default:
                begin
                    for (int k = 0; k < RANGE_REGS; k++)
                    begin
                        if (int'(reg_idx) == int'(REG_RANGE1) + k)
                        begin
                            range_reg[k] <= pwdata[RANGE_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_ROOT_SIZE:   prdata = 32'(root_size_reg);
            REG_ROOT_LEVEL:  prdata = 32'(root_level_reg);
            REG_RANGE_COUNT: prdata = 32'(range_count_reg);
            default:
            begin
                for (int k = 0; k < RANGE_REGS; k++)
                begin
                    if (int'(reg_idx) == int'(REG_RANGE1) + k)
                    begin
                        prdata = range_reg[k];
                    end
                end
            end
        endcase
    end

    assign cfg.root_size   = root_size_reg;
    assign cfg.root_level  = root_level_reg;
    assign cfg.range_count = range_count_reg;
    assign ranges          = range_reg;

endmodule

// ===== rtl/core/qlod_walk.sv =====
// ----------------------------------------------------------------------------
// qlod_walk
// depth first walk sequencer: path stack, node replay and emit decision
// ----------------------------------------------------------------------------
module qlod_walk #(
    parameter int MAX_LEVELS = qlod_pkg::MAX_LEVELS_DEF,
    parameter int RANGE_REGS = qlod_pkg::RANGE_REGS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     req_type,
    input  logic signed [qlod_pkg::EYE_W-1:0]        eye_x,
    input  logic signed [qlod_pkg::EYE_W-1:0]        eye_y,
    input  logic signed [qlod_pkg::EYE_W-1:0]        eye_z,
    input  qlod_pkg::qlod_cfg_t                      cfg,
    input  logic [RANGE_REGS-1:0][qlod_pkg::RANGE_W-1:0] ranges,
    output qlod_pkg::sq_cmd_t                        sq_cmd,
    input  qlod_pkg::sq_res_t                        sq_res,
    output logic                                     result_valid,
    output logic [1:0]                               status,
    output logic [15:0]                              node_x,
    output logic [15:0]                              node_y,
    output logic [qlod_pkg::COORD_W-1:0]             node_size,
    output logic [qlod_pkg::LEVEL_W-1:0]             node_level
);
    import qlod_pkg::*;

    localparam int DW = $clog2(MAX_LEVELS);
    localparam logic [DW-1:0]      DEPTH_LAST = DW'(MAX_LEVELS - 1);
    localparam logic [COUNT_W-1:0] EFF_MAX    = COUNT_W'(RANGE_REGS + 1);

    walk_state_t              state_reg, state_next;
    logic                     active_reg, active_next;
    logic                     to_test_reg, to_test_next;
    logic [DW-1:0]            depth_reg, depth_next;
    logic [DW-1:0]            d_reg, d_next;
    logic [COORD_W-1:0]       x_acc_reg, x_acc_next;
    logic [COORD_W-1:0]       y_acc_reg, y_acc_next;
    logic [COORD_W-1:0]       s_acc_reg, s_acc_next;
    logic [LEVEL_W-1:0]       l_acc_reg, l_acc_next;
    logic [COORD_W-1:0]       cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]       cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]       cur_size_reg, cur_size_next;
    logic [LEVEL_W-1:0]       cur_level_reg, cur_level_next;
    logic signed [EYE_W-1:0]  eye_x_reg, eye_x_next;
    logic signed [EYE_W-1:0]  eye_y_reg, eye_y_next;
    logic signed [EYE_W-1:0]  eye_z_reg, eye_z_next;
    logic                     rslt_valid_reg, rslt_valid_next;
    status_t                  status_reg, status_next;
    logic [15:0]              node_x_reg, node_x_next;
    logic [15:0]              node_y_reg, node_y_next;
    logic [COORD_W-1:0]       node_size_reg, node_size_next;
    logic [LEVEL_W-1:0]       node_level_reg, node_level_next;

    logic                     ram_we;
    logic [DW-1:0]            ram_waddr;
    logic [CHILD_W-1:0]       ram_wdata;
    logic [DW-1:0]            ram_raddr;
    logic [CHILD_W-1:0]       ram_rdata;

    logic                     emit_now;
    logic                     split_now;
    logic [COUNT_W-1:0]       eff_count;
    logic [COORD_W-1:0]       half;
    logic [COORD_W:0]         x_end;
    logic [COORD_W:0]         y_end;
    logic signed [33:0]       ex_w, ez_w, x_lo, x_hi, z_lo, z_hi;
    logic signed [32:0]       ey_w;
    logic [GAP_W-1:0]         gap_x, gap_z, gap_y;
    logic [RANGE_W-1:0]       range_sel;

    function automatic logic [GAP_W-1:0] axis_gap(
        input logic signed [33:0] e,
        input logic signed [33:0] lo,
        input logic signed [33:0] hi
    );
        logic signed [33:0] diff;
        diff = '0;
        if (e < lo)
        begin
            diff = lo - e;
        end
        else if (e > hi)
        begin
            diff = e - hi;
        end
        return diff[GAP_W-1:0];
    endfunction

    qlod_ram #(
        .WIDTH(CHILD_W),
        .DEPTH(MAX_LEVELS)
    ) u_path (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // distance operands
    assign x_end = {1'b0, cur_x_reg} + {1'b0, cur_size_reg};
    assign y_end = {1'b0, cur_y_reg} + {1'b0, cur_size_reg};
    assign ex_w  = {{2{eye_x_reg[EYE_W-1]}}, eye_x_reg};
    assign ez_w  = {{2{eye_z_reg[EYE_W-1]}}, eye_z_reg};
    assign ey_w  = {eye_y_reg[EYE_W-1], eye_y_reg};
    assign x_lo  = signed'({9'b0, cur_x_reg, 8'b0});
    assign x_hi  = signed'({8'b0, x_end, 8'b0});
    assign z_lo  = signed'({9'b0, cur_y_reg, 8'b0});
    assign z_hi  = signed'({8'b0, y_end, 8'b0});
    assign gap_x = axis_gap(ex_w, x_lo, x_hi);
    assign gap_z = axis_gap(ez_w, z_lo, z_hi);
    assign gap_y = (ey_w < 0) ? GAP_W'(-ey_w) : GAP_W'(ey_w);
    assign half  = s_acc_reg >> 1;

    assign eff_count = (cfg.range_count > EFF_MAX) ? EFF_MAX : cfg.range_count;

    always_comb
    begin
        range_sel = '0;
        for (int k = 0; k < RANGE_REGS; k++)
        begin
            if (LEVEL_W'(k + 1) == cur_level_reg)
            begin
                range_sel = ranges[k];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        to_test_next    = to_test_reg;
        depth_next      = depth_reg;
        d_next          = d_reg;
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        s_acc_next      = s_acc_reg;
        l_acc_next      = l_acc_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_size_next   = cur_size_reg;
        cur_level_next  = cur_level_reg;
        eye_x_next      = eye_x_reg;
        eye_y_next      = eye_y_reg;
        eye_z_next      = eye_z_reg;
        rslt_valid_next = 1'b0;
        status_next     = status_reg;
        node_x_next     = node_x_reg;
        node_y_next     = node_y_reg;
        node_size_next  = node_size_reg;
        node_level_next = node_level_reg;
        ram_we          = 1'b0;
        ram_waddr       = depth_reg;
        ram_wdata       = CHILD_FIRST;
        ram_raddr       = d_reg;
        sq_cmd.kind     = SQ_NONE;
        sq_cmd.op       = '0;
        emit_now        = 1'b0;
        split_now       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rslt_valid_next = 1'b1;
                    status_next     = STATUS_DONE;
                    node_x_next     = '0;
                    node_y_next     = '0;
                    node_size_next  = '0;
                    node_level_next = '0;
                    if (req_type == REQ_START)
                    begin
                        eye_x_next     = eye_x;
                        eye_y_next     = eye_y;
                        eye_z_next     = eye_z;
                        depth_next     = '0;
                        cur_x_next     = '0;
                        cur_y_next     = '0;
                        cur_size_next  = cfg.root_size;
                        cur_level_next = cfg.root_level;
                        active_next    = 1'b1;
                        status_next    = STATUS_STARTED;
                    end
                    else if (active_reg)
                    begin
                        rslt_valid_next = 1'b0;
                        state_next      = ST_TEST;
                    end
                end
            end
            ST_TEST:
            begin
                if (cur_level_reg == '0 || depth_reg >= DEPTH_LAST)
                begin
                    emit_now = 1'b1;
                end
                else if (cur_level_reg < LEVEL_W'(eff_count))
                begin
                    state_next = ST_DX;
                end
                else
                begin
                    split_now = 1'b1;
                end
            end
            ST_DX:
            begin
                sq_cmd.kind = SQ_LOAD;
                sq_cmd.op   = gap_x;
                state_next  = ST_DZ;
            end
            ST_DZ:
            begin
                sq_cmd.kind = SQ_ADD;
                sq_cmd.op   = gap_z;
                state_next  = ST_DY;
            end
            ST_DY:
            begin
                sq_cmd.kind = SQ_ADD;
                sq_cmd.op   = gap_y;
                state_next  = ST_DR;
            end
            ST_DR:
            begin
                sq_cmd.kind = SQ_CMP;
                sq_cmd.op   = GAP_W'(range_sel);
                state_next  = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (sq_res.done)
                begin
                    if (sq_res.in_range)
                    begin
                        split_now = 1'b1;
                    end
                    else
                    begin
                        emit_now = 1'b1;
                    end
                end
            end
            ST_LD_RD:
            begin
                if (d_reg == depth_reg)
                begin
                    cur_x_next     = x_acc_reg;
                    cur_y_next     = y_acc_reg;
                    cur_size_next  = s_acc_reg;
                    cur_level_next = l_acc_reg;
                    state_next     = to_test_reg ? ST_TEST : ST_IDLE;
                end
                else
                begin
                    state_next = ST_LD_ACC;
                end
            end
            ST_LD_ACC:
            begin
                if (ram_rdata[0])
                begin
                    x_acc_next = x_acc_reg + half;
                end
                if (ram_rdata[1])
                begin
                    y_acc_next = y_acc_reg + half;
                end
                s_acc_next = half;
                l_acc_next = l_acc_reg - 1'b1;
                d_next     = d_reg + 1'b1;
                state_next = ST_LD_RD;
            end
            ST_ADV_CHK:
            begin
                if (depth_reg == '0)
                begin
                    active_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = depth_reg - 1'b1;
                    state_next = ST_ADV_DATA;
                end
            end
            ST_ADV_DATA:
            begin
                if (ram_rdata == CHILD_LAST)
                begin
                    depth_next = depth_reg - 1'b1;
                    state_next = ST_ADV_CHK;
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = depth_reg - 1'b1;
                    ram_wdata    = ram_rdata + 1'b1;
                    x_acc_next   = '0;
                    y_acc_next   = '0;
                    s_acc_next   = cfg.root_size;
                    l_acc_next   = cfg.root_level;
                    d_next       = '0;
                    to_test_next = 1'b0;
                    state_next   = ST_LD_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_now)
        begin
            rslt_valid_next = 1'b1;
            status_next     = STATUS_NODE;
            node_x_next     = cur_x_reg[15:0];
            node_y_next     = cur_y_reg[15:0];
            node_size_next  = cur_size_reg;
            node_level_next = cur_level_reg;
            state_next      = ST_ADV_CHK;
        end

        // descend into the first child and rebuild it from the root
        if (split_now)
        begin
            ram_we       = 1'b1;
            ram_waddr    = depth_reg;
            ram_wdata    = CHILD_FIRST;
            depth_next   = depth_reg + 1'b1;
            x_acc_next   = '0;
            y_acc_next   = '0;
            s_acc_next   = cfg.root_size;
            l_acc_next   = cfg.root_level;
            d_next       = '0;
            to_test_next = 1'b1;
            state_next   = ST_LD_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            to_test_reg    <= 1'b0;
            depth_reg      <= '0;
            d_reg          <= '0;
            rslt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            to_test_reg    <= to_test_next;
            depth_reg      <= depth_next;
            d_reg          <= d_next;
            rslt_valid_reg <= rslt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_acc_reg      <= x_acc_next;
        y_acc_reg      <= y_acc_next;
        s_acc_reg      <= s_acc_next;
        l_acc_reg      <= l_acc_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        cur_size_reg   <= cur_size_next;
        cur_level_reg  <= cur_level_next;
        eye_x_reg      <= eye_x_next;
        eye_y_reg      <= eye_y_next;
        eye_z_reg      <= eye_z_next;
        status_reg     <= status_next;
        node_x_reg     <= node_x_next;
        node_y_reg     <= node_y_next;
        node_size_reg  <= node_size_next;
        node_level_reg <= node_level_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rslt_valid_reg;
    assign status       = status_reg;
    assign node_x       = node_x_reg;
    assign node_y       = node_y_reg;
    assign node_size    = node_size_reg;
    assign node_level   = node_level_reg;

    a_idle_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !active_reg) |-> depth_reg == '0)
        else $error("walk ended with nonzero depth");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_LAST)
        else $error("walk depth beyond stack");

    a_sq_done: assert property (@(posedge clk) disable iff (!rst_n)
        sq_res.done |-> state_reg == ST_DWAIT)
        else $error("distance result outside wait state");

    a_test_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TEST |-> active_reg)
        else $error("node test without running walk");

    a_node_src: assert property (@(posedge clk) disable iff (!rst_n)
        (rslt_valid_reg && status_reg == STATUS_NODE)
            |-> ($past(state_reg) == ST_TEST || $past(state_reg) == ST_DWAIT))
        else $error("node transaction from wrong state");

endmodule

// ===== rtl/core/quadtree_lod_node_selector.sv =====
// ----------------------------------------------------------------------------
// quadtree_lod_node_selector
// depth first quadtree terrain lod walk, one selected patch per fetch
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A start request
// (req_type 0) or a fetch with no walk running answers on the next cycle and
// busy stays low. A fetch walks the tree under a sequencer that shares one
// 33x33 squaring unit: each node passes a test state, a range tested node
// also sends four squares through the unit, then the compare, and each
// descent rebuilds the child from the root through the path stack ram, one
// level of depth at a time. After the result strobe the walk climbs past
// finished parents and steps to the next sibling, then the same rebuild,
// before busy drops. result_valid is high for exactly one cycle per
// transaction and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module quadtree_lod_node_selector #(
    parameter int MAX_LEVELS = qlod_pkg::MAX_LEVELS_DEF,
    parameter int RANGE_REGS = qlod_pkg::RANGE_REGS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic signed [qlod_pkg::EYE_W-1:0] eye_x,
    input  logic signed [qlod_pkg::EYE_W-1:0] eye_y,
    input  logic signed [qlod_pkg::EYE_W-1:0] eye_z,
    output logic                              result_valid,
    output logic [1:0]                        status,
    output logic [15:0]                       node_x,
    output logic [15:0]                       node_y,
    output logic [qlod_pkg::COORD_W-1:0]      node_size,
    output logic [qlod_pkg::LEVEL_W-1:0]      node_level,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qlod_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import qlod_pkg::*;

    qlod_cfg_t                          cfg;
    logic [RANGE_REGS-1:0][RANGE_W-1:0] ranges;
    sq_cmd_t                            sq_cmd;
    sq_res_t                            sq_res;

    qlod_cfg #(
        .RANGE_REGS(RANGE_REGS)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg),
        .ranges (ranges)
    );

    qlod_sq u_sq (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (sq_cmd),
        .res  (sq_res)
    );

    qlod_walk #(
        .MAX_LEVELS(MAX_LEVELS),
        .RANGE_REGS(RANGE_REGS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .eye_x       (eye_x),
        .eye_y       (eye_y),
        .eye_z       (eye_z),
        .cfg         (cfg),
        .ranges      (ranges),
        .sq_cmd      (sq_cmd),
        .sq_res      (sq_res),
        .result_valid(result_valid),
        .status      (status),
        .node_x      (node_x),
        .node_y      (node_y),
        .node_size   (node_size),
        .node_level  (node_level)
    );

endmodule

// ===== tb/tb_quadtree_lod_node_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadtree_lod_node_selector
// self-checking testbench of the quadtree lod node selector
//
// Drives start and fetch transactions through the start/busy handshake. It
// programs the register map over apb, but only while the block is idle. A
// behavioral model of the depth first walk predicts each result, and a
// monitor compares every result strobe with the oldest prediction.
// Directed cases come first: no walk running, extreme eyes, config changes
// in mid walk, a single leaf root, the range count cap and a deep stack.
// Randomized walks follow over many register settings.
// ----------------------------------------------------------------------------
module tb_quadtree_lod_node_selector;
    import qlod_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [15:0]         x;
        logic [15:0]         y;
        logic [COORD_W-1:0]  size;
        logic [LEVEL_W-1:0]  level;
    } node_pick_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic signed [31:0]  eye_x;
    logic signed [31:0]  eye_y;
    logic signed [31:0]  eye_z;
    logic                result_valid;
    logic [1:0]          status;
    logic [15:0]         node_x;
    logic [15:0]         node_y;
    logic [COORD_W-1:0]  node_size;
    logic [LEVEL_W-1:0]  node_level;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic [COORD_W-1:0]  cfg_root_size;
    logic [LEVEL_W-1:0]  cfg_root_level;
    logic [COUNT_W-1:0]  cfg_range_count;
    logic [31:0]         cfg_range [RANGE_REGS_DEF];

    logic [CHILD_W-1:0]  trail [MAX_LEVELS_DEF];
    int unsigned         trail_depth;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  pos_size;
    logic [LEVEL_W-1:0]  pos_level;
    bit                  walking;
    logic [31:0]         eye_pos_x;
    logic [31:0]         eye_pos_y;
    logic [31:0]         eye_pos_z;

    node_pick_t          pending_nodes [$];
    node_pick_t          want;
    int                  mismatch_count;
    int                  item_count;
    bit                  idle_on;

    quadtree_lod_node_selector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .eye_x        (eye_x),
        .eye_y        (eye_y),
        .eye_z        (eye_z),
        .result_valid (result_valid),
        .status       (status),
        .node_x       (node_x),
        .node_y       (node_y),
        .node_size    (node_size),
        .node_level   (node_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // rebuild the current node from the root along the child path
    function void rebuild_node();
        int unsigned x;
        int unsigned y;
        int unsigned s;
        int unsigned h;
        int unsigned l;
        int unsigned d;
        x = 0;
        y = 0;
        s = cfg_root_size;
        l = cfg_root_level;
        for (d = 0; d < trail_depth && d < MAX_LEVELS_DEF; d++)
        begin
            h = s >> 1;
            if (trail[d][0])
                x += h;
            if (trail[d][1])
                y += h;
            s = h;
            l = (l - 1) & 15;
        end
        pos_x     = x[COORD_W-1:0];
        pos_y     = y[COORD_W-1:0];
        pos_size  = s[COORD_W-1:0];
        pos_level = l[LEVEL_W-1:0];
    endfunction

    function automatic longint unsigned box_gap(longint e, longint lo, longint hi);
        if (e < lo)
            return longint'(lo - e);
        if (e > hi)
            return longint'(e - hi);
        return 0;
    endfunction

    function node_pick_t select_next(req_t kind, logic [31:0] ex, logic [31:0] ey,
                                     logic [31:0] ez);
        node_pick_t        r;
        int unsigned       eff;
        bit                emit;
        longint unsigned   dx;
        longint unsigned   dy;
        longint unsigned   dz;
        longint unsigned   rng;
        longint            x0;
        longint            z0;
        r.status = STATUS_DONE;
        r.x      = '0;
        r.y      = '0;
        r.size   = '0;
        r.level  = '0;
        if (kind == REQ_START)
        begin
            eye_pos_x = ex;
            eye_pos_y = ey;
            eye_pos_z = ez;
            for (int i = 0; i < MAX_LEVELS_DEF; i++)
                trail[i] = CHILD_FIRST;
            trail_depth = 0;
            rebuild_node();
            walking  = 1'b1;
            r.status = STATUS_STARTED;
            return r;
        end
        if (!walking)
            return r;
        eff = (cfg_range_count > RANGE_REGS_DEF + 1) ? RANGE_REGS_DEF + 1 : cfg_range_count;
        while (1)
        begin
            if (pos_level == 0 || trail_depth >= MAX_LEVELS_DEF - 1)
                emit = 1'b1;
            else if (pos_level < eff)
            begin
                x0  = longint'(pos_x) * 256;
                z0  = longint'(pos_y) * 256;
                dx  = box_gap(longint'(signed'(eye_pos_x)), x0,
                              x0 + longint'(pos_size) * 256);
                dz  = box_gap(longint'(signed'(eye_pos_z)), z0,
                              z0 + longint'(pos_size) * 256);
                dy  = box_gap(longint'(signed'(eye_pos_y)), 0, 0);
                rng = cfg_range[(pos_level - 1) % RANGE_REGS_DEF];
                emit = !(dx * dx + dy * dy + dz * dz <= rng * rng);
            end
            else
                emit = 1'b0;
            if (emit)
            begin
                r.status = STATUS_NODE;
                r.x      = pos_x[15:0];
                r.y      = pos_y[15:0];
                r.size   = pos_size;
                r.level  = pos_level;
                // climb past finished parents, then step to the next sibling
                while (trail_depth > 0 && trail[(trail_depth - 1) & 15] == CHILD_LAST)
                    trail_depth--;
                if (trail_depth == 0)
                    walking = 1'b0;
                else
                begin
                    trail[(trail_depth - 1) & 15] = trail[(trail_depth - 1) & 15] + 1;
                    rebuild_node();
                end
                return r;
            end
            trail[trail_depth & 15] = CHILD_FIRST;
            trail_depth++;
            rebuild_node();
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_nodes.size() == 0)
                note_mismatch($sformatf("unexpected result got %0d %h %h %h %0d",
                              status, node_x, node_y, node_size, node_level));
            else
            begin
                want = pending_nodes.pop_front();
                if (status !== want.status || node_x !== want.x || node_y !== want.y ||
                    node_size !== want.size || node_level !== want.level)
                    note_mismatch($sformatf("exp %0d %h %h %h %0d got %0d %h %h %h %0d",
                                  want.status, want.x, want.y, want.size, want.level,
                                  status, node_x, node_y, node_size, node_level));
            end
        end
    end

    task automatic send_item(input req_t kind, input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] ez);
        int         gap;
        node_pick_t pick;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        eye_x    <= ex;
        eye_y    <= ey;
        eye_z    <= ez;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pick = select_next(kind, ex, ey, ez);
        pending_nodes = {pending_nodes, pick};
        item_count++;
    endtask

    task automatic fetch_node();
        send_item(REQ_FETCH, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ROOT_SIZE:   cfg_root_size   = value[COORD_W-1:0];
            REG_ROOT_LEVEL:  cfg_root_level  = value[LEVEL_W-1:0];
            REG_RANGE_COUNT: cfg_range_count = value[COUNT_W-1:0];
            default:         cfg_range[idx - REG_RANGE1] = value;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_reg(input reg_idx_t idx);
        logic [31:0] value;
        case (idx)
            REG_ROOT_SIZE:
                case ($urandom_range(0, 5))
                    0:       value = 1;
                    1:       value = 65536;
                    2:       value = 1 << $urandom_range(1, 16);
                    3:       value = $urandom_range(1, 65536);
                    4:       value = (1 << $urandom_range(2, 12)) + 1;
                    default: value = $urandom_range(1, 300);
                endcase
            REG_ROOT_LEVEL:
                case ($urandom_range(0, 9))
                    0:       value = 0;
                    1, 2:    value = $urandom_range(6, 15);
                    default: value = $urandom_range(1, 5);
                endcase
            REG_RANGE_COUNT:
                value = $urandom_range(0, 7);
            default:
                case ($urandom_range(0, 7))
                    0:       value = 0;
                    1:       value = 32'hFFFF_FFFF;
                    2:       value = $urandom;
                    default: value = $urandom_range(0,
                                 (int'(cfg_root_size) * 512) >> $urandom_range(0, 8));
                endcase
        endcase
        write_reg(idx, value);
    endtask

    task automatic test_reset_state();
        idle_on = 1'b0;
        fetch_node();
        send_item(REQ_START, 32'd0, 32'd0, 32'd0);
        repeat (3) fetch_node();
    endtask

    task automatic test_eye_extremes();
        idle_on = 1'b1;
        send_item(REQ_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        repeat (2) fetch_node();
        send_item(REQ_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        repeat (2) fetch_node();
    endtask

    task automatic test_config_mid_walk();
        send_item(REQ_START, 32'h0004_0000, 32'h0000_0100, 32'h0004_0000);
        repeat (2) fetch_node();
        wait_idle();
        write_reg(REG_ROOT_SIZE, 32'd4097);
        write_reg(REG_ROOT_LEVEL, 32'd6);
        repeat (2) fetch_node();
        send_item(REQ_START, 32'h0001_0000, 32'h0000_0800, 32'h0003_0000);
        fetch_node();
    endtask

    task automatic test_single_leaf();
        wait_idle();
        write_reg(REG_ROOT_SIZE, 32'd1);
        write_reg(REG_ROOT_LEVEL, 32'd0);
        send_item(REQ_START, 32'd0, 32'd0, 32'd0);
        repeat (3) fetch_node();
    endtask

    task automatic test_range_count_cap();
        wait_idle();
        write_reg(REG_ROOT_SIZE, 32'd65536);
        write_reg(REG_ROOT_LEVEL, 32'd5);
        write_reg(REG_RANGE_COUNT, 32'd7);
        for (int i = 0; i < RANGE_REGS_DEF; i++)
            write_reg(reg_idx_t'(REG_RANGE1 + i), 32'd0);
        send_item(REQ_START, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
        repeat (2) fetch_node();
    endtask

    task automatic test_deep_stack();
        wait_idle();
        write_reg(REG_ROOT_LEVEL, 32'd15);
        write_reg(REG_RANGE_COUNT, 32'd0);
        send_item(REQ_START, 32'd0, 32'd0, 32'd0);
        repeat (2) fetch_node();
    endtask

    task automatic test_random_walks();
        int first;
        int span;
        int ex;
        int ey;
        int ez;
        int fetches;
        int n;
        bit until_done;
        first = item_count;
        while (item_count - first < 1850)
        begin
            wait_idle();
            for (int i = 0; i < 8; i++)
                program_reg(reg_idx_t'(i));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 6))
            begin
                span = int'(cfg_root_size) * 256;
                if ($urandom_range(0, 7) == 0)
                begin
                    ex = $urandom;
                    ey = $urandom;
                    ez = $urandom;
                end
                else
                begin
                    ex = $urandom_range(0, span + span / 2) - span / 4;
                    ez = $urandom_range(0, span + span / 2) - span / 4;
                    ey = $urandom_range(0, span / 2);
                    if ($urandom_range(0, 1))
                        ey = -ey;
                end
                send_item(REQ_START, ex, ey, ez);
                until_done = (cfg_root_level <= 3) && ($urandom_range(0, 1) == 1);
                fetches = until_done ? 200 : $urandom_range(1, 30);
                for (n = 0; n < fetches && (walking || !until_done); n++)
                begin
                    if ($urandom_range(0, 60) == 0)
                    begin
                        wait_idle();
                        program_reg(reg_idx_t'($urandom_range(0, 7)));
                    end
                    fetch_node();
                end
                if (until_done)
                    repeat ($urandom_range(1, 2)) fetch_node();
            end
        end
    endtask

    initial
    begin
        int drain;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_START;
        eye_x    = '0;
        eye_y    = '0;
        eye_z    = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_root_size   = ROOT_SIZE_RST;
        cfg_root_level  = ROOT_LEVEL_RST;
        cfg_range_count = RANGE_COUNT_RST;
        for (int i = 0; i < RANGE_REGS_DEF; i++)
            cfg_range[i] = RANGE_RST[i];
        for (int i = 0; i < MAX_LEVELS_DEF; i++)
            trail[i] = CHILD_FIRST;
        trail_depth    = 0;
        pos_x          = '0;
        pos_y          = '0;
        pos_size       = '0;
        pos_level      = '0;
        walking        = 1'b0;
        eye_pos_x      = '0;
        eye_pos_y      = '0;
        eye_pos_z      = '0;
        mismatch_count = 0;
        item_count     = 0;
        idle_on        = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_eye_extremes();
        test_config_mid_walk();
        test_single_leaf();
        test_range_count_cap();
        test_deep_stack();
        test_random_walks();

        @(negedge clk);
        start <= 1'b0;
        drain = 0;
        while (pending_nodes.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (500) @(posedge clk);
        mismatch_count += pending_nodes.size();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
